@@ sv/mau_pkg.sv @@
// ---------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Residue modulus, field widths, operation codes and the multiplier request
// and response bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package mau_pkg;

  // field widths
  localparam int unsigned ModeW = 3;   // operation selector
  localparam int unsigned ResW  = 30;  // residue width
  localparam int unsigned OpbW  = 63;  // second operand width
  localparam int unsigned CntW  = 6;   // bit counter of the serial multiplier

  // stream bus widths
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 32;

  // prime modulus and derived constants
  localparam logic [ResW-1:0] Modulus      = 30'd1000000007;
  localparam logic [ResW-1:0] ModMinusTwo  = 30'd1000000005;
  localparam logic [ResW+1:0] ModTwice     = 32'd2000000014;

  // default exponent width
  localparam int unsigned ExpWidthDefault = 63;

  // operation codes
  typedef enum logic [ModeW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4,
    OP_DIV = 3'd5
  } op_e;

  // request to the serial multiplier; x is consumed from its msb
  typedef struct packed {
    logic            start;
    logic [OpbW-1:0] x;
    logic [ResW-1:0] y;
    logic [CntW-1:0] nbits;
  } mul_req_t;

  // multiplier status and product
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [ResW-1:0] prod;
  } mul_rsp_t;

endpackage : mau_pkg

`default_nettype wire

@@ sv/mau_mulmod.sv @@
// ---------------------------------------------------------------------------
// mau_mulmod: bit-serial modular multiplier
// Interleaved shift-and-add: one multiplier bit per cycle, msb first, the
// running sum kept below the modulus by a parallel compare-and-subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module mau_mulmod (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire mau_pkg::mul_req_t req_i,
  output mau_pkg::mul_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [mau_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [mau_pkg::OpbW-1:0]      x_q, x_d;
  logic [mau_pkg::ResW-1:0]      y_q, y_d;
  logic [mau_pkg::ResW-1:0]      acc_q, acc_d;

  logic [mau_pkg::ResW+1:0]      sum;
  logic [mau_pkg::ResW+1:0]      addend;

  // one step: acc = 2*acc + bit*y, then fold back below the modulus
  always_comb begin
    addend = x_q[mau_pkg::OpbW-1] ? {2'b00, y_q} : '0;
    sum    = {1'b0, acc_q, 1'b0} + addend;
  end

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      x_d    = req_i.x;
      y_d    = req_i.y;
      acc_d  = '0;
    end else if (busy_q) begin
      x_d = {x_q[mau_pkg::OpbW-2:0], 1'b0};
      if (sum >= mau_pkg::ModTwice) begin
        acc_d = mau_pkg::ResW'(sum - mau_pkg::ModTwice);
      end else if (sum >= {2'b00, mau_pkg::Modulus}) begin
        acc_d = mau_pkg::ResW'(sum - {2'b00, mau_pkg::Modulus});
      end else begin
        acc_d = sum[mau_pkg::ResW-1:0];
      end
      cnt_d = cnt_q - mau_pkg::CntW'(1);
      if (cnt_q == mau_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule : mau_mulmod

`default_nettype wire

@@ sv/modular_arithmetic_unit_core.sv @@
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_core: residue arithmetic modulo 1000000007
// Add, subtract, multiply, power, inverse and divide on one shared
// bit-serial modular multiplier.
// ---------------------------------------------------------------------------
// One transaction is handled at a time; a new one is taken once the previous
// result sits in the output register. Every modular product runs through one
// bit-serial multiplier at one bit per cycle.
// Add and subtract first reduce the second operand serially over its 63 bits;
// multiply then adds one product. Power costs one squaring per exponent bit
// below the highest set bit plus one product per set bit; inverse raises to
// the exponent p-2. Unused mode codes answer 0.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_arithmetic_unit_core #(
  parameter int unsigned EXP_WIDTH = mau_pkg::ExpWidthDefault
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [mau_pkg::InDataW-1:0]       s_axis_tdata,  // [29:0] operand_a, [92:30] operand_b
  input  wire [mau_pkg::ModeW-1:0]         s_axis_tuser,  // [2:0] mode
  // output stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [mau_pkg::OutDataW-1:0]     m_axis_tdata   // [29:0] result
);

  localparam int unsigned PadW = mau_pkg::OpbW - mau_pkg::ResW;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REDB = 3'd1;
  localparam logic [2:0] ST_PBIT = 3'd2;
  localparam logic [2:0] ST_PMUL = 3'd3;
  localparam logic [2:0] ST_PSQ  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [mau_pkg::ModeW-1:0]     mode_q, mode_d;
  logic [mau_pkg::ResW-1:0]      a_q, a_d;
  logic [mau_pkg::ResW-1:0]      acc_q, acc_d;
  logic [mau_pkg::ResW-1:0]      sq_q, sq_d;
  logic [mau_pkg::ResW-1:0]      res_q, res_d;
  logic [EXP_WIDTH-1:0]          exp_q, exp_d;
  logic                          out_valid_q, out_valid_d;
  logic [mau_pkg::ResW-1:0]      out_data_q, out_data_d;

  logic [mau_pkg::ResW-1:0]      in_a;
  logic [mau_pkg::OpbW-1:0]      in_b;
  logic [mau_pkg::ModeW-1:0]     in_mode;
  logic [mau_pkg::ResW-1:0]      in_a_red;
  logic [mau_pkg::ResW:0]        add_sum;
  logic [mau_pkg::ResW:0]        sub_diff;
  logic                          in_take;

  mau_pkg::mul_req_t             mul_req;
  mau_pkg::mul_rsp_t             mul_rsp;

  // unpack the input transaction
  assign in_a    = s_axis_tdata[mau_pkg::ResW-1:0];
  assign in_b    = s_axis_tdata[mau_pkg::ResW+mau_pkg::OpbW-1:mau_pkg::ResW];
  assign in_mode = s_axis_tuser;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // first operand is below twice the modulus, one subtract reduces it
  assign in_a_red = (in_a >= mau_pkg::Modulus) ? (in_a - mau_pkg::Modulus) : in_a;

  // add and subtract of two reduced residues
  always_comb begin
    add_sum  = {1'b0, a_q} + {1'b0, mul_rsp.prod};
    sub_diff = {1'b0, a_q} + {1'b0, mau_pkg::Modulus} - {1'b0, mul_rsp.prod};
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    a_d           = a_q;
    acc_d         = acc_q;
    sq_d          = sq_q;
    res_d         = res_q;
    exp_d         = exp_q;
    mul_req.start = 1'b0;
    mul_req.x     = {acc_q, {PadW{1'b0}}};
    mul_req.y     = sq_q;
    mul_req.nbits = mau_pkg::CntW'(mau_pkg::ResW);

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          mode_d = in_mode;
          a_d    = in_a_red;
          acc_d  = mau_pkg::ResW'(1);
          sq_d   = in_a_red;
          case (in_mode) inside
            mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_MUL, mau_pkg::OP_DIV: begin
              // reduce the second operand: multiply it by one, bit by bit
              mul_req.start = 1'b1;
              mul_req.x     = in_b;
              mul_req.y     = mau_pkg::ResW'(1);
              mul_req.nbits = mau_pkg::CntW'(mau_pkg::OpbW);
              state_d       = ST_REDB;
            end
            mau_pkg::OP_POW: begin
              exp_d   = EXP_WIDTH'(in_b);
              state_d = ST_PBIT;
            end
            mau_pkg::OP_INV: begin
              exp_d   = EXP_WIDTH'(mau_pkg::ModMinusTwo);
              state_d = ST_PBIT;
            end
            default: begin
              res_d   = '0;
              state_d = ST_OUT;
            end
          endcase
        end
      end

      ST_REDB: begin
        if (mul_rsp.done) begin
          case (mode_q)
            mau_pkg::OP_ADD: begin
              res_d = (add_sum >= {1'b0, mau_pkg::Modulus})
                      ? mau_pkg::ResW'(add_sum - {1'b0, mau_pkg::Modulus})
                      : add_sum[mau_pkg::ResW-1:0];
              state_d = ST_OUT;
            end
            mau_pkg::OP_SUB: begin
              res_d = (sub_diff >= {1'b0, mau_pkg::Modulus})
                      ? mau_pkg::ResW'(sub_diff - {1'b0, mau_pkg::Modulus})
                      : sub_diff[mau_pkg::ResW-1:0];
              state_d = ST_OUT;
            end
            mau_pkg::OP_MUL: begin
              mul_req.start = 1'b1;
              mul_req.x     = {a_q, {PadW{1'b0}}};
              mul_req.y     = mul_rsp.prod;
              state_d       = ST_FIN;
            end
            default: begin
              // divide: invert the reduced divisor first
              sq_d    = mul_rsp.prod;
              acc_d   = mau_pkg::ResW'(1);
              exp_d   = EXP_WIDTH'(mau_pkg::ModMinusTwo);
              state_d = ST_PBIT;
            end
          endcase
        end
      end

      // right-to-left square-and-multiply, one exponent bit per pass
      ST_PBIT: begin
        if (exp_q == '0) begin
          if (mode_q == mau_pkg::OP_DIV) begin
            mul_req.start = 1'b1;
            mul_req.x     = {a_q, {PadW{1'b0}}};
            mul_req.y     = acc_q;
            state_d       = ST_FIN;
          end else begin
            res_d   = acc_q;
            state_d = ST_OUT;
          end
        end else if (exp_q[0]) begin
          mul_req.start = 1'b1;
          mul_req.x     = {acc_q, {PadW{1'b0}}};
          mul_req.y     = sq_q;
          state_d       = ST_PMUL;
        end else begin
          mul_req.start = 1'b1;
          mul_req.x     = {sq_q, {PadW{1'b0}}};
          mul_req.y     = sq_q;
          state_d       = ST_PSQ;
        end
      end

      ST_PMUL: begin
        if (mul_rsp.done) begin
          acc_d   = mul_rsp.prod;
          exp_d   = {exp_q[EXP_WIDTH-1:1], 1'b0};
          state_d = ST_PBIT;
        end
      end

      ST_PSQ: begin
        if (mul_rsp.done) begin
          sq_d    = mul_rsp.prod;
          exp_d   = {1'b0, exp_q[EXP_WIDTH-1:1]};
          state_d = ST_PBIT;
        end
      end

      ST_FIN: begin
        if (mul_rsp.done) begin
          res_d   = mul_rsp.prod;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_OUT) && (!out_valid_q || m_axis_tready)) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end
  end

  // shared serial multiplier
  mau_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    a_q        <= a_d;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    res_q      <= res_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(mau_pkg::OutDataW-mau_pkg::ResW){1'b0}}, out_data_q};

  // multiplier is never restarted while a product is in flight
  a_mul_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_req.start && mul_rsp.busy))
    else $error("multiplier started while busy");

  // accepting a transaction implies the multiplier is idle
  a_ready_mul_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_rsp.busy)
    else $error("input ready while multiplier busy");

  // a product only completes in a state that waits for it
  a_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_REDB || state_q == ST_PMUL ||
                      state_q == ST_PSQ || state_q == ST_FIN))
    else $error("multiplier done in unexpected state");

  // a result that raises the output valid is a reduced residue
  a_result_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[mau_pkg::ResW-1:0] < mau_pkg::Modulus))
    else $error("result not below the modulus");

endmodule : modular_arithmetic_unit_core

`default_nettype wire
